/* rtl/lafe_pkg.sv */
package lafe_pkg;

   localparam int COLUMNS = 5;
   localparam int ROWS    = 8;
   localparam int CELL_W  = 20;
   localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int EXP_DEPTH = 256;

   localparam logic [1:0] OP_PROGRAM = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_EVAL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // per-column control handed to the column evaluator
   typedef struct packed {
      logic            first;     // column 0: links read the pattern
      logic            second;    // column 1: far links read the pattern
      logic [ROWS-1:0] cell_vld;  // cell programmed since reset
   } col_ctl_type;

   // value of one link selector
   function automatic logic link_bit(
      input logic            first,
      input logic            second,
      input logic [3:0]      sel,
      input logic [ROWS-1:0] pattern,
      input logic [ROWS-1:0] prev1,
      input logic [ROWS-1:0] prev2
   );
      logic [2:0] r;
      logic       b;
      r = sel[2:0];
      if (!sel[3]) begin
         b = first ? pattern[r] : prev1[r];
      end else if (first) begin
         b = ~pattern[r];
      end else if (second) begin
         b = pattern[r];
      end else begin
         b = prev2[r];
      end
      return b;
   endfunction

endpackage

/* rtl/lafe_ram.sv */
module lafe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lafe_column.sv */
module lafe_column (
   input  lafe_pkg::col_ctl_type          ctl,
   input  logic [lafe_pkg::CELL_W-1:0]    cell_word [lafe_pkg::ROWS],
   input  logic [lafe_pkg::ROWS-1:0]      pattern,
   input  logic [lafe_pkg::ROWS-1:0]      prev1,
   input  logic [lafe_pkg::ROWS-1:0]      prev2,
   output logic [lafe_pkg::ROWS-1:0]      vec
);
   import lafe_pkg::*;

   // one LUT cell per row, all rows of the column in parallel
   always_comb begin
      logic [CELL_W-1:0] w;
      logic [2:0]        idx;
      vec = '0;
      for (int r = 0; r < ROWS; r++) begin
         w      = ctl.cell_vld[r] ? cell_word[r] : '0;  // unprogrammed cell reads zero
         idx[0] = link_bit(ctl.first, ctl.second, w[3:0], pattern, prev1, prev2);
         idx[1] = link_bit(ctl.first, ctl.second, w[7:4], pattern, prev1, prev2);
         idx[2] = link_bit(ctl.first, ctl.second, w[11:8], pattern, prev1, prev2);
         vec[r] = w[12 + idx];
      end
   end

endmodule

/* rtl/lut_array_fitness_evaluator_core.sv */
// LUT array fitness evaluator. A feed-forward array of COLUMNS x 8 three-input
// LUT cells is held in eight per-row config RAMs (one word per column), and a
// 256-entry expected-output RAM. Program and load items return nothing; op
// code 3 is dropped. An evaluate item is accepted, then the array is walked
// one column per cycle: the column's eight cell words come out of the row
// RAMs while the next column's read is issued. No further item is taken
// until the walk is done, and after the last column the block waits for as
// long as the result register is still full. The match byte sits in an
// output register, so a new item can be accepted while it waits for
// rsp_ready. Cells never programmed since reset read as all-zero words
// (per-cell valid flops, no clearing pass). Reading an expected entry that
// was never loaded returns an undefined match.
// csr_match_mask is always ready; write it only while the block is idle.
module lut_array_fitness_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_column,
   input  logic [2:0]  req_row,
   input  logic [19:0] req_cell_word,
   input  logic [7:0]  req_pattern,
   input  logic [7:0]  req_expected,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_match,
   // config write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_match_mask
);
   import lafe_pkg::*;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   state_type state_ff, state_in;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROWS-1:0]  pattern_ff, pattern_in;
   logic [ROWS-1:0]  prev1_ff, prev1_in;       // most recent column vector
   logic [ROWS-1:0]  prev2_ff, prev2_in;       // column before that
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_match_ff, rsp_match_in;
   logic [7:0]       mask_ff, mask_in;
   logic [ROWS-1:0]  cell_vld_ff [COLUMNS];

   logic req_xfer, prog_xfer, load_xfer, eval_xfer;
   logic out_free, last_col;

   logic             cell_rd_en;
   logic [COL_W-1:0] cell_rd_addr;
   logic [ROWS-1:0]  cell_wr_en;
   logic [CELL_W-1:0] cell_rd_data [ROWS];
   logic [7:0]       exp_rd_data;

   col_ctl_type      col_ctl;
   logic [ROWS-1:0]  col_vec;
   logic [ROWS-1:0]  fin_vec;
   logic             fin_load;

   assign req_xfer  = req_valid && req_ready;
   assign prog_xfer = req_xfer && (req_op == OP_PROGRAM) && (int'(req_column) < COLUMNS);
   assign load_xfer = req_xfer && (req_op == OP_LOAD);
   assign eval_xfer = req_xfer && (req_op == OP_EVAL);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_col  = (col_ff == LAST_COL);

   // ---------------------------------------------------------------- storage
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      assign cell_wr_en[r] = prog_xfer && (req_row == 3'(r));

      lafe_ram #(
         .WIDTH (CELL_W),
         .DEPTH (COLUMNS)
      ) u_cell_ram (
         .clock   (clock),
         .wr_en   (cell_wr_en[r]),
         .wr_addr (COL_W'(req_column)),
         .wr_data (req_cell_word),
         .rd_en   (cell_rd_en),
         .rd_addr (cell_rd_addr),
         .rd_data (cell_rd_data[r])
      );
   end

   // read once per evaluate at accept; data holds until the next evaluate
   lafe_ram #(
      .WIDTH (8),
      .DEPTH (EXP_DEPTH)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (req_pattern),
      .wr_data (req_expected),
      .rd_en   (eval_xfer),
      .rd_addr (req_pattern),
      .rd_data (exp_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMNS; c++) begin
            cell_vld_ff[c] <= '0;
         end
      end else if (prog_xfer) begin
         cell_vld_ff[COL_W'(req_column)][req_row] <= 1'b1;
      end
   end

   // ---------------------------------------------------------- column logic
   assign col_ctl.first    = (col_ff == '0);
   assign col_ctl.second   = (col_ff == COL_W'(1));
   assign col_ctl.cell_vld = cell_vld_ff[col_ff];

   lafe_column u_column (
      .ctl       (col_ctl),
      .cell_word (cell_rd_data),
      .pattern   (pattern_ff),
      .prev1     (prev1_ff),
      .prev2     (prev2_ff),
      .vec       (col_vec)
   );

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_xfer) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_col) begin
               state_in = out_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_ready    = 1'b0;
      cell_rd_en   = 1'b0;
      cell_rd_addr = '0;
      fin_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cell_rd_en = eval_xfer;          // fetch column 0 at accept
         end
         ST_RUN: begin
            cell_rd_en   = !last_col;        // prefetch the next column
            cell_rd_addr = col_ff + COL_W'(1);
            fin_load     = last_col && out_free;
         end
         ST_DONE: begin
            fin_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign fin_vec = (state_ff == ST_RUN) ? col_vec : prev1_ff;

   // ---------------------------------------------------------- datapath regs
   always_comb begin
      col_in       = col_ff;
      pattern_in   = pattern_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      mask_in      = mask_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eval_xfer) begin
         col_in     = '0;
         pattern_in = req_pattern;
      end
      if (state_ff == ST_RUN) begin
         prev1_in = col_vec;
         prev2_in = prev1_ff;
         if (!last_col) begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (fin_load) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = ~(fin_vec ^ exp_rd_data) & mask_ff;
      end
      if (csr_valid && csr_ready) begin
         mask_in = csr_match_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= 8'hFF;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff   <= pattern_in;
      prev1_ff     <= prev1_in;
      prev2_ff     <= prev2_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;
   assign csr_ready = 1'b1;

endmodule

/* rtl/lafe_checker.sv */
module lafe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_match
);
   import lafe_pkg::*;

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an evaluate holds off further requests while the array is walked
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_EVAL) |=> !req_ready)
      else $error("request taken during evaluate");

   // program, load and unused items never produce a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op != OP_EVAL && !rsp_valid) |=> !rsp_valid)
      else $error("result from a non-evaluate item");

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_match)))
      else $error("result dropped or changed while stalled");

endmodule

bind lut_array_fitness_evaluator_core lafe_checker u_lafe_checker (.*);
